// ===== hdl/rbe_pkg.sv =====
// shared types and constants for the reversed base64 encoder
package rbe_pkg;

  // alphabet register file geometry
  localparam int AlphaWords = 8;
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 64;
  localparam int CharW      = 8;
  localparam int IdxW       = 6;

  // control sequencer states
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // shift commands broadcast to every cell of the byte chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

// ===== hdl/rbe_ifs.sv =====
// valid/ready channel interfaces for input bytes, output characters and configuration

interface rbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface rbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic       overflow;

  modport source (output valid, output out_char, output out_last, output overflow, input ready);
  modport sink   (input valid, input out_char, input out_last, input overflow, output ready);
endinterface

interface rbe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rbe_pkg::CfgIdxW-1:0]    index;
  logic [rbe_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rbe_cell.sv =====
// one byte cell of the push/pop chain
module rbe_cell (
  input  logic                 clk,
  input  rbe_pkg::shift_ctrl_t ctrl,
  input  logic [7:0]           from_left,
  input  logic [7:0]           from_right,
  output logic [7:0]           data_q
);

  logic [7:0] data_r;

  // push takes the left neighbor, pop takes the right neighbor
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      data_r <= from_left;
    end else if (ctrl.pop) begin
      data_r <= from_right;
    end
  end

  assign data_q = data_r;

endmodule

// ===== hdl/rbe_alphabet.sv =====
// alphabet register file and 6-bit index to character lookup
module rbe_alphabet (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [rbe_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [rbe_pkg::CfgDataW-1:0]  wr_data,
  input  logic [rbe_pkg::IdxW-1:0]      idx,
  output logic [rbe_pkg::CharW-1:0]     char_out
);

  logic [rbe_pkg::CfgDataW-1:0] alpha_r [rbe_pkg::AlphaWords];
  logic [rbe_pkg::CfgDataW-1:0] word_sel;

  // register writes, indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < rbe_pkg::AlphaWords; w++) begin
        alpha_r[w] <= '0;
      end
    end else if (wr_en && (wr_index < rbe_pkg::CfgIdxW'(rbe_pkg::AlphaWords))) begin
      alpha_r[wr_index[2:0]] <= wr_data;
    end
  end

  // word by upper index bits, byte lane by lower bits
  always_comb begin
    word_sel = alpha_r[idx[5:3]];
    char_out = word_sel[{idx[2:0], 3'b000} +: rbe_pkg::CharW];
  end

endmodule

// ===== hdl/reversed_base64_encoder.sv =====
// top level of the reversed base64 encoder
//
// Message bytes enter on in_ch, one beat per byte, in_last set on the final
// byte. Bytes are pushed into a chain of MAX_BYTES cells; the newest byte
// sits in the head cell, so popping the chain yields the message reversed.
// A byte that arrives with the chain full is dropped and sets the overflow
// flag carried by every character of that message.
// After the final byte the block stops taking input and emits the base64
// encoding on out_ch, one character per cycle while the output is not stalled,
// through the alphabet held in eight 64-bit registers written on cfg_ch
// (cfg_ch is always ready). in_ch.ready is high only while bytes are loading.
// When the receiver stalls, the output register holds its beat and the
// chain pauses. Synchronous reset empties the chain, clears the overflow
// flag and alphabet registers and drops any pending output beat.
module reversed_base64_encoder #(
  parameter int MAX_BYTES = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  rbe_in_if.sink      in_ch,
  rbe_out_if.source   out_ch,
  rbe_cfg_if.sink     cfg_ch
);

  localparam int CntW = $clog2(MAX_BYTES + 1);

  rbe_pkg::state_t      state_r, state_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r;
  logic [7:0]           out_char_r;
  logic                 out_last_r;
  logic                 out_ovf_r;

  rbe_pkg::shift_ctrl_t ctrl;
  logic [7:0]           cell_q [MAX_BYTES];
  logic [7:0]           second_q;
  logic [7:0]           head;
  logic [7:0]           nxt_byte;
  logic                 in_acc;
  logic                 emit_go;
  logic                 is_last;
  logic [5:0]           idx;
  logic [7:0]           alpha_char;

  // byte chain
  genvar gi;
  generate
    for (gi = 0; gi < MAX_BYTES; gi++) begin : g_cell
      logic [7:0] left_d;
      logic [7:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = in_ch.in_byte;
      end else begin : g_mid
        assign left_d = cell_q[gi-1];
      end
      if (gi == MAX_BYTES - 1) begin : g_end
        assign right_d = cell_q[gi];
      end else begin : g_inner
        assign right_d = cell_q[gi+1];
      end
      rbe_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .from_left  (left_d),
        .from_right (right_d),
        .data_q     (cell_q[gi])
      );
    end
    if (MAX_BYTES > 1) begin : g_second
      assign second_q = cell_q[1];
    end else begin : g_nosecond
      assign second_q = '0;
    end
  endgenerate

  assign head     = cell_q[0];
  assign nxt_byte = (cnt_r > CntW'(1)) ? second_q : 8'h00;

  // handshakes
  assign in_ch.ready  = (state_r == rbe_pkg::ST_LOAD);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign emit_go      = (state_r == rbe_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  // pick the 6-bit index for this phase of the group
  always_comb begin
    case (phase_r)
      2'd0:    idx = head[7:2];
      2'd1:    idx = {head[1:0], nxt_byte[7:4]};
      2'd2:    idx = {head[3:0], nxt_byte[7:6]};
      2'd3:    idx = head[5:0];
      default: idx = head[5:0];
    endcase
  end

  assign is_last = (phase_r != 2'd0) && (cnt_r == CntW'(1));

  // sequencer and counters
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    ovf_nxt   = ovf_r;
    ctrl.push = 1'b0;
    ctrl.pop  = 1'b0;
    case (state_r)
      rbe_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CntW'(MAX_BYTES)) begin
            ctrl.push = 1'b1;
            cnt_nxt   = cnt_r + CntW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.in_last) begin
            state_nxt = rbe_pkg::ST_EMIT;
            phase_nxt = 2'd0;
          end
        end
      end
      rbe_pkg::ST_EMIT: begin
        if (emit_go) begin
          phase_nxt = phase_r + 2'd1;
          if (phase_r != 2'd0) begin
            ctrl.pop = 1'b1;
            cnt_nxt  = cnt_r - CntW'(1);
          end
          if (is_last) begin
            state_nxt = rbe_pkg::ST_LOAD;
            cnt_nxt   = '0;
            phase_nxt = 2'd0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = rbe_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbe_pkg::ST_LOAD;
      cnt_r   <= '0;
      phase_r <= 2'd0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // alphabet registers and lookup
  rbe_alphabet u_alpha (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid && cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .idx      (idx),
    .char_out (alpha_char)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_char_r <= alpha_char;
      out_last_r <= is_last;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.out_last = out_last_r;
  assign out_ch.overflow = out_ovf_r;

endmodule

// ===== hdl/rbe_checker.sv =====
// port-level checks for the reversed base64 encoder, bound to the top level
module rbe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic       overflow
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last)
      && $stable(overflow))
    else $error("stalled output beat changed");

  // no byte taken in the middle of an encoding
  a_no_load_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready during encoding");

  // final byte closes the input side
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still ready after final byte");

  // characters follow back to back with one overflow flag per message
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && (overflow == $past(overflow)))
    else $error("gap or overflow change inside an encoding");

endmodule

bind reversed_base64_encoder rbe_checker u_rbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.in_last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .out_last  (out_ch.out_last),
  .overflow  (out_ch.overflow)
);

// ===== dv/rbe_checker.sv =====
// checker for the reversed base64 encoder: watches all channels, predicts and compares
module rbe_tb_checker #(
  parameter int MAX_BYTES = 48
) (
  input  logic clk,
  input  logic rst_n,
  rbe_in_if    in_mon,
  rbe_out_if   out_mon,
  rbe_cfg_if   cfg_mon,
  output int   mismatches,
  output int   chars_pending,
  output int   chars_checked
);

  // one expected character beat
  typedef struct packed {
    logic [rbe_pkg::CharW-1:0] code;
    logic                      tail;
    logic                      dropped;
  } enc_char_t;

  logic [rbe_pkg::CfgDataW-1:0] alpha_words [rbe_pkg::AlphaWords];
  logic [7:0]                   msg_bytes [MAX_BYTES];
  int                           kept = 0;
  logic                         lost = 1'b0;
  enc_char_t                    enc_fifo [$];
  enc_char_t                    head;
  int                           errs = 0;
  int                           seen = 0;

  // alphabet character n lives in byte n%8 of word n/8
  function automatic logic [rbe_pkg::CharW-1:0] lookup(input logic [rbe_pkg::IdxW-1:0] sel);
    return alpha_words[sel[5:3]][sel[2:0]*8 +: 8];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0h want %0h (char %0d)", what, got, want, seen);
    errs++;
  endtask

  // encode the kept bytes newest first, no padding on the tail
  task automatic queue_encoding();
    logic [7:0]               b0, b1, b2;
    logic [rbe_pkg::IdxW-1:0] sel [$];
    enc_char_t                c;
    int                       i;
    int                       n;
    n = kept;
    for (i = 0; i + 2 < n; i += 3) begin
      b0 = msg_bytes[n-1-i];
      b1 = msg_bytes[n-2-i];
      b2 = msg_bytes[n-3-i];
      sel.push_back(b0[7:2]);
      sel.push_back({b0[1:0], b1[7:4]});
      sel.push_back({b1[3:0], b2[7:6]});
      sel.push_back(b2[5:0]);
    end
    // one or two bytes left over
    if (i < n) begin
      b0 = msg_bytes[n-1-i];
      sel.push_back(b0[7:2]);
      if (i + 1 == n) begin
        sel.push_back({b0[1:0], 4'h0});
      end else begin
        b1 = msg_bytes[n-2-i];
        sel.push_back({b0[1:0], b1[7:4]});
        sel.push_back({b1[3:0], 2'b00});
      end
    end
    foreach (sel[k]) begin
      c.code    = lookup(sel[k]);
      c.tail    = (k == sel.size() - 1);
      c.dropped = lost;
      enc_fifo.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (alpha_words[k]) alpha_words[k] = '0;
      kept = 0;
      lost = 1'b0;
      enc_fifo.delete();
    end else begin
      // register writes, indexes past the alphabet are ignored
      if (cfg_mon.valid && cfg_mon.ready && cfg_mon.index < rbe_pkg::AlphaWords) begin
        alpha_words[cfg_mon.index[2:0]] = cfg_mon.data;
      end

      // compare each character beat against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        seen++;
        if (enc_fifo.size() == 0) begin
          report_mismatch("unexpected char", out_mon.out_char, 0);
        end else begin
          head = enc_fifo.pop_front();
          if (out_mon.out_char !== head.code)
            report_mismatch("out_char", out_mon.out_char, head.code);
          if (out_mon.out_last !== head.tail)
            report_mismatch("out_last", out_mon.out_last, head.tail);
          if (out_mon.overflow !== head.dropped)
            report_mismatch("overflow", out_mon.overflow, head.dropped);
        end
      end

      // byte beats fill the store until full, then set the drop flag
      if (in_mon.valid && in_mon.ready) begin
        if (kept < MAX_BYTES) begin
          msg_bytes[kept] = in_mon.in_byte;
          kept++;
        end else begin
          lost = 1'b1;
        end
        if (in_mon.in_last) begin
          queue_encoding();
          kept = 0;
          lost = 1'b0;
        end
      end
    end
    mismatches    <= errs;
    chars_pending <= enc_fifo.size();
    chars_checked <= seen;
  end

endmodule

// ===== dv/testbench.sv =====
// top of the reversed base64 encoder testbench: stimulus, stalls and verdict
module testbench;

  localparam int MaxBytes   = 48;
  localparam int StallLimit = 2000;
  localparam int RandBytes  = 105;

  typedef enum int {
    ALPHA_STD,
    ALPHA_ZERO,
    ALPHA_ONES,
    ALPHA_IDENT,
    ALPHA_RANDOM
  } alpha_style_t;

  logic clk;
  logic rst_n;
  logic calm;
  int   mismatches;
  int   chars_pending;
  int   chars_checked;
  int   msgs_sent;
  int   bytes_sent;
  int   alpha_loads;

  // directed messages: single bytes at the extremes, zero runs, every tail length
  logic [7:0] dir_bytes [25] = '{
    8'h00,
    8'hFF,
    8'hA5, 8'h5A,
    8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF,
    8'h12, 8'h34, 8'h56, 8'h78,
    8'h01, 8'h80, 8'h7F, 8'hFE, 8'h10,
    8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h00, 8'h01
  };
  int dir_lens [8] = '{1, 1, 2, 3, 3, 4, 5, 6};

  rbe_in_if  in_ch ();
  rbe_out_if out_ch ();
  rbe_cfg_if cfg_ch ();

  reversed_base64_encoder #(.MAX_BYTES(MaxBytes)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rbe_tb_checker #(.MAX_BYTES(MaxBytes)) enc_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .mismatches    (mismatches),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] std_char(input int n);
    if (n < 26) return 8'(65 + n);
    if (n < 52) return 8'(97 + n - 26);
    if (n < 62) return 8'(48 + n - 52);
    if (n == 62) return 8'd43;
    return 8'd47;
  endfunction

  // write all eight alphabet words, then one write to an unused index
  task automatic load_alphabet(input alpha_style_t style);
    logic [rbe_pkg::CfgDataW-1:0] w;
    int                           k;
    int                           j;
    for (k = 0; k < rbe_pkg::AlphaWords; k++) begin
      case (style)
        ALPHA_STD: begin
          for (j = 0; j < 8; j++) w[j*8 +: 8] = std_char(k * 8 + j);
        end
        ALPHA_ZERO: begin
          w = '0;
        end
        ALPHA_ONES: begin
          w = '1;
        end
        ALPHA_IDENT: begin
          for (j = 0; j < 8; j++) w[j*8 +: 8] = 8'(k * 8 + j);
        end
        default: begin
          w = {$urandom, $urandom};
        end
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= rbe_pkg::CfgIdxW'(k);
      cfg_ch.data  <= w;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= rbe_pkg::CfgIdxW'($urandom_range(rbe_pkg::AlphaWords,
                                                     2**rbe_pkg::CfgIdxW - 1));
    cfg_ch.data  <= {$urandom, $urandom};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    alpha_loads++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= lst;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_message(input logic [7:0] msg [$]);
    foreach (msg[k]) push_byte(msg[k], k == msg.size() - 1);
    bytes_sent += msg.size();
    msgs_sent++;
  endtask

  // let every expected character come out, then a few quiet cycles
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // receiver side with random stalls
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // end the run if no beat moves on any channel for too long
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= StallLimit) begin
        $display("timeout: no beat for %0d cycles", idle);
        $display("[reversed_base64_encoder] ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0]   msg [$];
    alpha_style_t style;
    int           pos;
    int           len;
    int           m;
    int           phase;
    int           msg_no;
    int           rand_bytes;

    calm          = 1'b1;
    msgs_sent     = 0;
    bytes_sent    = 0;
    alpha_loads   = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first two messages run on the reset alphabet
    pos = 0;
    for (m = 0; m < 8; m++) begin
      if (m == 2) begin
        settle();
        load_alphabet(ALPHA_STD);
      end
      msg.delete();
      repeat (dir_lens[m]) begin
        msg.push_back(dir_bytes[pos]);
        pos++;
      end
      send_message(msg);
    end
    settle();

    // random phases, each under its own alphabet
    phase      = 0;
    msg_no     = 0;
    rand_bytes = 0;
    while (rand_bytes < RandBytes) begin
      calm = (phase % 3 == 0);
      case (phase % 5)
        0:       style = ALPHA_ONES;
        1:       style = ALPHA_RANDOM;
        2:       style = ALPHA_ZERO;
        3:       style = ALPHA_IDENT;
        default: style = ALPHA_RANDOM;
      endcase
      load_alphabet(style);
      repeat (3) begin
        // one message fills the store exactly, one overruns it past the final byte
        if (msg_no == 1)      len = MaxBytes;
        else if (msg_no == 4) len = MaxBytes + 2;
        else                  len = $urandom_range(1, 7);
        msg.delete();
        repeat (len) msg.push_back(8'($urandom));
        send_message(msg);
        rand_bytes += len;
        msg_no++;
      end
      settle();
      phase++;
    end

    $display("sent %0d messages (%0d bytes) under %0d alphabet loads",
             msgs_sent, bytes_sent, alpha_loads);
    $display("checked %0d encoded characters, including full and overrun stores",
             chars_checked);
    if (mismatches == 0) begin
      $display("[reversed_base64_encoder] OK");
    end else begin
      $display("[reversed_base64_encoder] ERROR");
    end
    $finish;
  end

endmodule
